// File: rtl/core/lsq_pkg.sv
// Shared types, codes and constants for the load/store queue.
// No dependencies.
package lsq_pkg;

  localparam int LSQ_QUEUE_DEPTH = 16;
  localparam int LSQ_MAX_RESULTS = 16;

  localparam int ADDR_W = 48;
  localparam int DATA_W = 64;
  localparam int SEQ_W  = 32;
  localparam int TAG_W  = 4;
  localparam int KIND_W = 3;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 144;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STORE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESOLVE = 3'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DROP,
    ST_RETIRE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              data_known;
    logic [DATA_W-1:0] data;
    logic              address_known;
    logic [ADDR_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic              is_store;
    logic [ADDR_W-1:0] address;
    logic              address_valid;
    logic [DATA_W-1:0] data;
    logic              data_valid;
    logic [SEQ_W-1:0]  sequence_num;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic occupied;
    logic shift;
    logic write;
    logic resolve;
  } cell_ctl_t;

endpackage

// File: rtl/core/load_store_queue_resolve_commit.sv
// Load/store queue with tag resolve and in-order store commit.
// A transaction is taken in ST_IDLE; ready head entries then retire in ST_RETIRE,
// and no new transaction is taken until the block is back in ST_IDLE. The head
// cell drains one entry a cycle; a store there stalls while a pending store waits for the output register.
// Reset: synchronous; queue empties, access counter clears, output idles.
// Depends on lsq_pkg and lsq_cell.
module load_store_queue_resolve_commit
  import lsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = LSQ_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // address, address_known, data, data_known, tag, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // kind
  input  logic [KIND_W-1:0]      s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // commit_address, commit_data, commit_access_number
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic                   m_tuser,
  output logic                   m_tlast
);

  localparam int NCELL = QUEUE_DEPTH - 1;
  localparam int CW    = $clog2(QUEUE_DEPTH);
  localparam int RW    = $clog2(LSQ_MAX_RESULTS + 1);

  state_t state, state_next;

  logic [CW-1:0]    count;
  logic [SEQ_W-1:0] access_counter;
  logic [RW-1:0]    retired;
  logic             pend_valid;
  entry_t           pend;

  item_t  item;
  entry_t cells  [NCELL];
  entry_t ups    [NCELL];
  logic   found  [NCELL+1];

  logic accept, is_mem, full, do_enq, do_rsv, do_drop;
  logic retirable, out_free;
  logic do_shift, load_pend, push_out, push_last, push_drop;

  assign item   = item_t'(s_tdata[$bits(item_t)-1:0]);
  assign accept = s_tvalid && s_tready;
  assign is_mem = (s_tuser == KIND_LOAD) || (s_tuser == KIND_STORE);
  assign full   = (count == CW'(NCELL));
  assign do_enq  = accept && is_mem && !full;
  assign do_drop = accept && is_mem && full;
  assign do_rsv  = accept && (s_tuser == KIND_RESOLVE);

  assign retirable = (count != '0) && cells[0].address_valid && cells[0].data_valid &&
                     (retired < RW'(LSQ_MAX_RESULTS));
  assign out_free  = !m_tvalid || m_tready;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cell_ctl_t ctl;
    if (i == NCELL - 1) begin : g_end
      assign ups[i] = '0;
    end else begin : g_mid
      assign ups[i] = cells[i+1];
    end
    assign ctl.occupied = (CW'(i) < count);
    assign ctl.shift    = do_shift;
    assign ctl.write    = do_enq && (CW'(i) == count);
    assign ctl.resolve  = do_rsv;
    lsq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .item         (item),
      .item_is_store(s_tuser == KIND_STORE),
      .item_seq     (access_counter),
      .upstream     (ups[i]),
      .found_in     (found[i]),
      .found_out    (found[i+1]),
      .entry        (cells[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (do_drop) begin
          state_next = ST_DROP;
        end else if (accept) begin
          state_next = ST_RETIRE;
        end
      end
      ST_DROP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RETIRE: begin
        if (!retirable && (!pend_valid || out_free)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    do_shift  = 1'b0;
    load_pend = 1'b0;
    push_out  = 1'b0;
    push_last = 1'b0;
    push_drop = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DROP: push_drop = out_free;
      ST_RETIRE: begin
        if (retirable) begin
          if (!cells[0].is_store) begin
            do_shift = 1'b1;
          end else if (!pend_valid) begin
            do_shift  = 1'b1;
            load_pend = 1'b1;
          end else if (out_free) begin
            do_shift  = 1'b1;
            load_pend = 1'b1;
            push_out  = 1'b1;
          end
        end else if (pend_valid && out_free) begin
          push_out  = 1'b1;
          push_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      access_counter <= '0;
      retired        <= '0;
      pend_valid     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (do_enq) begin
        count          <= count + 1'b1;
        access_counter <= access_counter + 1'b1;
      end else if (do_shift) begin
        count <= count - 1'b1;
      end
      if (accept) begin
        retired <= '0;
      end else if (do_shift) begin
        retired <= retired + 1'b1;
      end
      if (load_pend) begin
        pend_valid <= 1'b1;
      end else if (push_last) begin
        pend_valid <= 1'b0;
      end
      if (push_out || push_drop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_pend) begin
      pend <= cells[0];
    end
    if (push_drop) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
      m_tlast <= 1'b1;
    end else if (push_out) begin
      m_tdata <= {pend.sequence_num, pend.data, pend.address};
      m_tuser <= 1'b0;
      m_tlast <= push_last;
    end
  end

endmodule

// File: rtl/core/lsq_cell.sv
// One queue slot: holds an entry, shifts toward the head, takes enqueues and
// resolves. Depends on lsq_pkg.
module lsq_cell
  import lsq_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  item_t            item,
  input  logic             item_is_store,
  input  logic [SEQ_W-1:0] item_seq,
  input  entry_t           upstream,
  input  logic             found_in,
  output logic             found_out,
  output entry_t           entry
);

  entry_t entry_next;
  logic   match;

  assign match = ctl.occupied && (entry.tag == item.tag) && !found_in &&
                 !(entry.address_valid && entry.data_valid);
  assign found_out = found_in || match;

  always_comb begin
    entry_next = entry;
    if (ctl.shift) begin
      entry_next = upstream;
    end else if (ctl.write) begin
      entry_next.is_store      = item_is_store;
      entry_next.address       = item.address;
      entry_next.address_valid = item.address_known;
      entry_next.data          = item.data;
      entry_next.data_valid    = item.data_known;
      entry_next.sequence_num  = item_seq;
      entry_next.tag           = item.tag;
    end else if (ctl.resolve && match) begin
      if (item.address_known) begin
        entry_next.address       = item.address;
        entry_next.address_valid = 1'b1;
      end
      if (item.data_known) begin
        entry_next.data       = item.data;
        entry_next.data_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: rtl/core/lsq_checker.sv
// Port-level checks for load_store_queue_resolve_commit, with its bind.
// Depends on lsq_pkg.
module lsq_checker
  import lsq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   m_tlast
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_drop_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("drop transaction not final or not zero");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output transaction changed");

endmodule

bind load_store_queue_resolve_commit lsq_checker u_lsq_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// File: sim/lsq_commit_checker.sv
// Checker for the load/store queue: mirrors the queue from accepted input
// transactions and compares each output transaction with the predicted commit.
// Depends on lsq_pkg.
module lsq_commit_checker
  import lsq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]      s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tuser,
  input  logic                   m_tlast,
  output int                     mismatch_count,
  output int                     pending_count
);

  typedef struct packed {
    logic              is_store;
    logic [ADDR_W-1:0] address;
    logic              address_ok;
    logic [DATA_W-1:0] data;
    logic              data_ok;
    logic [SEQ_W-1:0]  seq;
    logic [TAG_W-1:0]  tag;
  } slot_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } commit_t;

  slot_t            slots [LSQ_QUEUE_DEPTH];
  int               head_idx;
  int               tail_idx;
  logic [SEQ_W-1:0] access_count;
  commit_t          commits_due [$];
  int               errors;

  initial begin
    head_idx       = 0;
    tail_idx       = 0;
    access_count   = '0;
    errors         = 0;
    mismatch_count = 0;
    pending_count  = 0;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      report($sformatf("%s expected %h, got %h", name, want, got));
    end
  endtask

  task automatic apply_operation(input logic [KIND_W-1:0] kind, input item_t it);
    int      p;
    int      retired;
    int      stores_out;
    bit      found;
    commit_t c;
    if (kind == KIND_LOAD || kind == KIND_STORE) begin
      if ((tail_idx + LSQ_QUEUE_DEPTH - head_idx) % LSQ_QUEUE_DEPTH >= LSQ_QUEUE_DEPTH - 1) begin
        c = '0;
        c.status = 1'b1;
        c.last = 1'b1;
        commits_due.push_back(c);
        return;
      end
      slots[tail_idx].is_store   = (kind == KIND_STORE);
      slots[tail_idx].address    = it.address;
      slots[tail_idx].address_ok = it.address_known;
      slots[tail_idx].data       = it.data;
      slots[tail_idx].data_ok    = it.data_known;
      slots[tail_idx].seq        = access_count;
      slots[tail_idx].tag        = it.tag;
      access_count = access_count + 1'b1;
      tail_idx = (tail_idx + 1) % LSQ_QUEUE_DEPTH;
    end else if (kind == KIND_RESOLVE) begin
      p = head_idx;
      found = 1'b0;
      while (p != tail_idx && !found) begin
        if (slots[p].tag == it.tag && !(slots[p].address_ok && slots[p].data_ok)) begin
          found = 1'b1;
          if (it.address_known) begin
            slots[p].address    = it.address;
            slots[p].address_ok = 1'b1;
          end
          if (it.data_known) begin
            slots[p].data    = it.data;
            slots[p].data_ok = 1'b1;
          end
        end
        p = (p + 1) % LSQ_QUEUE_DEPTH;
      end
    end
    retired = 0;
    stores_out = 0;
    while (head_idx != tail_idx && retired < LSQ_MAX_RESULTS &&
           slots[head_idx].address_ok && slots[head_idx].data_ok) begin
      if (slots[head_idx].is_store) begin
        c.status  = 1'b0;
        c.address = slots[head_idx].address;
        c.data    = slots[head_idx].data;
        c.seq     = slots[head_idx].seq;
        c.last    = 1'b0;
        commits_due.push_back(c);
        stores_out++;
      end
      head_idx = (head_idx + 1) % LSQ_QUEUE_DEPTH;
      retired++;
    end
    if (stores_out > 0) begin
      commits_due[commits_due.size()-1].last = 1'b1;
    end
  endtask

  task automatic check_commit();
    commit_t c;
    if (commits_due.size() == 0) begin
      report($sformatf("unexpected output transaction, tdata %h", m_tdata));
      return;
    end
    c = commits_due.pop_front();
    check_field("status", 64'(c.status), 64'(m_tuser));
    check_field("commit_address", 64'(c.address), 64'(m_tdata[ADDR_W-1:0]));
    check_field("commit_data", c.data, m_tdata[ADDR_W +: DATA_W]);
    check_field("commit_access_number", 64'(c.seq), 64'(m_tdata[ADDR_W+DATA_W +: SEQ_W]));
    check_field("last", 64'(c.last), 64'(m_tlast));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_idx     = 0;
      tail_idx     = 0;
      access_count = '0;
      commits_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        apply_operation(s_tuser, s_tdata[$bits(item_t)-1:0]);
      end
      if (m_tvalid && m_tready) begin
        check_commit();
      end
    end
    mismatch_count <= errors;
    pending_count  <= commits_due.size();
  end

endmodule

// File: sim/tb_load_store_queue_resolve_commit.sv
// Testbench top for the load/store queue: drives directed and random trace
// operations with random idling on both sides and gives the verdict.
// Depends on lsq_pkg, load_store_queue_resolve_commit and lsq_commit_checker.
module tb_load_store_queue_resolve_commit;
  import lsq_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  int                     mismatch_count;
  int                     pending_count;
  bit                     quiet = 1'b0;
  int                     stall_left = 0;
  int                     counted;

  load_store_queue_resolve_commit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  lsq_commit_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rst && !quiet && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= !rst;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_address();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
  endfunction

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    if ($urandom_range(0, 3) == 0) begin
      return TAG_W'($urandom_range(0, 15));
    end
    return TAG_W'($urandom_range(0, 3));
  endfunction

  task automatic issue(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] address,
                       input logic address_known, input logic [DATA_W-1:0] data,
                       input logic data_known, input logic [TAG_W-1:0] tag);
    item_t it;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    it.address       = address;
    it.address_known = address_known;
    it.data          = data;
    it.data_known    = data_known;
    it.tag           = tag;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_TDATA_W-$bits(item_t)){1'b0}}, it};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic fill_behind_blocker(input logic [TAG_W-1:0] tag, input bit extremes);
    logic [KIND_W-1:0] kind;
    issue(KIND_LOAD, rand_address(), 1'b0, rand_data(), 1'b0, tag);
    for (int i = 0; i < LSQ_QUEUE_DEPTH - 2; i++) begin
      kind = (i % 3 == 2) ? KIND_LOAD : KIND_STORE;
      if (extremes && i == 0) begin
        issue(kind, '1, 1'b1, '1, 1'b1, 4'hF);
      end else if (extremes && i == 1) begin
        issue(kind, '0, 1'b1, '0, 1'b1, 4'h0);
      end else begin
        issue(kind, rand_address(), 1'b1, rand_data(), 1'b1, rand_tag());
      end
    end
  endtask

  task automatic random_operation();
    int                r;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      kind = KIND_STORE;
    end else if (r < 6) begin
      kind = KIND_LOAD;
    end else if (r < 9) begin
      kind = KIND_RESOLVE;
    end else begin
      kind = KIND_W'($urandom_range(3, 7));
    end
    issue(kind, rand_address(), $urandom_range(0, 3) != 0, rand_data(),
          $urandom_range(0, 3) != 0, rand_tag());
    if (r < 9) begin
      counted++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    fill_behind_blocker(4'h1, 1'b1);
    issue(KIND_STORE, rand_address(), 1'b1, rand_data(), 1'b1, 4'h2);
    issue(KIND_LOAD, rand_address(), 1'b1, rand_data(), 1'b1, 4'h3);
    for (int k = 3; k <= 7; k++) begin
      issue(KIND_W'(k), rand_address(), 1'b1, rand_data(), 1'b1, 4'h1);
    end
    issue(KIND_RESOLVE, rand_address(), 1'b1, rand_data(), 1'b1, 4'h9);
    issue(KIND_RESOLVE, rand_address(), 1'b0, rand_data(), 1'b0, 4'h1);
    issue(KIND_RESOLVE, rand_address(), 1'b1, rand_data(), 1'b0, 4'h1);
    issue(KIND_RESOLVE, rand_address(), 1'b0, rand_data(), 1'b1, 4'h1);

    counted = 0;
    while (counted < 80) begin
      if (counted == 20 || counted == 45) begin
        fill_behind_blocker(4'hE, 1'b0);
        issue(KIND_STORE, rand_address(), 1'b1, rand_data(), 1'b1, rand_tag());
        issue(KIND_RESOLVE, rand_address(), 1'b1, rand_data(), 1'b1, 4'hE);
        counted += LSQ_QUEUE_DEPTH + 1;
      end
      if (counted >= 65) begin
        quiet = 1'b1;
      end
      random_operation();
    end
    s_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lsq_pkg.sv
rtl/core/lsq_cell.sv
rtl/core/load_store_queue_resolve_commit.sv
rtl/core/lsq_checker.sv
sim/lsq_commit_checker.sv
sim/tb_load_store_queue_resolve_commit.sv
